// ----- design/bzf_pkg.sv -----
// Shared types, constants and state codes of the cubic Bezier flattener.
package bzf_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int MAX_DEPTH_DEF  = 5;

	localparam logic [31:0] TOL_FLOOR = 32'd49;
	localparam logic [31:0] TOL_RESET = 32'd42949;

	// Multiply-accumulate datapath widths.
	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 100;
	localparam int LEN_W  = 66;
	localparam int CABS_W = 49;
	localparam int CLO_W  = 24;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] ctrl1_x;
		logic signed [31:0] ctrl1_y;
		logic signed [31:0] ctrl2_x;
		logic signed [31:0] ctrl2_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic               path_start;
		logic               path_end;
		logic               path_closed;
	} seg_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               move_to;
		logic               run_last;
	} point_t;

	typedef enum logic [3:0] {
		B_IDLE, B_START, B_PREP, B_MAC, B_ACCEPT,
		B_POP, B_SPLIT, B_SPLIT2, B_CLOSE, B_FLUSH
	} bstate_t;

	typedef enum logic [3:0] {
		M_UXDY, M_UYDX, M_ABS, M_CHH, M_CHL, M_CLL, M_DXDX,
		M_DYDY, M_LLO, M_LHI, M_DONE, M_UXUX, M_UYUY, M_DGDONE
	} mstep_t;

endpackage

// ----- design/bzf_stream_if.sv -----
// Valid/ready stream channel carrying one payload type.
interface bzf_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- design/bzf_front.sv -----
// Front stage: accepts segment requests and normalizes coordinates.
module bzf_front import bzf_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bzf_stream_if.sink   segment,
	output logic         push_valid,
	input  logic         push_ready,
	output seg_t         push_data
);

	logic slot_v_q;
	seg_t slot_q;

	// Coordinates are read as COORD_BITS-bit two's complement values.
	function automatic logic signed [31:0] sx(logic [31:0] v);
		return 32'(signed'(v[COORD_BITS-1:0]));
	endfunction

	assign segment.ready = !slot_v_q || push_ready;
	assign push_valid    = slot_v_q;
	assign push_data     = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_v_q <= 1'b0;
		end else if (segment.ready) begin
			slot_v_q <= segment.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (segment.valid && segment.ready) begin
			slot_q.start_x     <= sx(segment.data.start_x);
			slot_q.start_y     <= sx(segment.data.start_y);
			slot_q.ctrl1_x     <= sx(segment.data.ctrl1_x);
			slot_q.ctrl1_y     <= sx(segment.data.ctrl1_y);
			slot_q.ctrl2_x     <= sx(segment.data.ctrl2_x);
			slot_q.ctrl2_y     <= sx(segment.data.ctrl2_y);
			slot_q.end_x       <= sx(segment.data.end_x);
			slot_q.end_y       <= sx(segment.data.end_y);
			slot_q.path_start  <= segment.data.path_start;
			slot_q.path_end    <= segment.data.path_end;
			slot_q.path_closed <= segment.data.path_closed;
		end
	end

endmodule

// ----- design/bzf_queue.sv -----
// Two-entry queue between the front stage and the subdivision engine.
module bzf_queue import bzf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  seg_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output seg_t pop_data
);

	seg_t       mem_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

// ----- design/bzf_back.sv -----
// Subdivision engine: stack walk, flatness tests and point emission.
module bzf_back import bzf_pkg::*; #(
	parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   tol,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  seg_t          pop_data,
	bzf_stream_if.source  point
);

	localparam int CW    = COORD_BITS;
	localparam int DW    = CW + 1;
	localparam int SLOTS = MAX_DEPTH + 1;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int SP_W  = $clog2(SLOTS + 1);
	localparam int LVL_W = $clog2(MAX_DEPTH + 1);

	typedef logic signed [CW-1:0] crd_t;
	typedef logic signed [DW-1:0] dif_t;
	typedef struct packed {
		crd_t x;
		crd_t y;
	} cpt_t;

	bstate_t state_q, state_d;

	cpt_t q0_q, q1_q, q2_q, q3_q;
	logic [LVL_W-1:0] lvl_q;
	logic [SP_W-1:0]  sp_q;
	logic [SP_W-1:0]  sp_dec;
	cpt_t stk_p0 [SLOTS];
	cpt_t stk_p1 [SLOTS];
	cpt_t stk_p2 [SLOTS];
	cpt_t stk_p3 [SLOTS];
	logic [LVL_W-1:0] stk_lvl [SLOTS];

	cpt_t prev_q, first_q;
	logic end_q, closed_q, sel_q;
	cpt_t ma_q, mb_q, mc_q;
	cpt_t sp_ab, sp_bc, sp_m;

	dif_t ux_q, uy_q, dx_q, dy_q;
	cpt_t tp;
	mstep_t step_q, step_nx;
	logic ph_q;
	logic signed [MUL_W-1:0]  op_a, op_b;
	logic [5:0]               op_sh;
	logic                     op_sub, op_clr;
	logic signed [PROD_W-1:0] prod_q;
	logic [5:0]               sh_q;
	logic                     sub_q, clr_q;
	logic signed [ACC_W-1:0]  acc_q, acc_base, addend, acc_nxt, mag;
	logic [ACC_W-1:0]         c2_q;
	logic [LEN_W-1:0]         len_q;
	logic [CABS_W-1:0]        cabs_q;
	logic                     big, pass;

	logic   pend_v_q, pend_mv_q;
	cpt_t   pend_q;
	logic   out_v_q;
	point_t out_q;
	logic   can_out, can_move;
	logic   emit_req, emit_mv, flush_req;
	cpt_t   emit_pt;

	function automatic crd_t midc(crd_t a, crd_t b);
		logic signed [CW:0] s;
		s = {a[CW-1], a} + {b[CW-1], b};
		return s[CW:1];
	endfunction

	function automatic cpt_t midp(cpt_t a, cpt_t b);
		cpt_t r;
		r.x = midc(a.x, b.x);
		r.y = midc(a.y, b.y);
		return r;
	endfunction

	function automatic dif_t subc(crd_t a, crd_t b);
		return {a[CW-1], a} - {b[CW-1], b};
	endfunction

	assign sp_dec   = sp_q - 1'b1;
	assign tp       = sel_q ? q2_q : q1_q;
	assign sp_ab    = midp(ma_q, mb_q);
	assign sp_bc    = midp(mb_q, mc_q);
	assign sp_m     = midp(sp_ab, sp_bc);
	assign can_out  = !out_v_q || point.ready;
	assign can_move = !pend_v_q || can_out;
	assign point.valid = out_v_q;
	assign point.data  = out_q;

	// Steps: cross product, magnitude check, cross squared, chord length
	// squared, length times tolerance, compare; point chord: distance squared.
	always_comb begin
		op_a    = '0;
		op_b    = '0;
		op_sh   = 6'd0;
		op_sub  = 1'b0;
		op_clr  = 1'b0;
		step_nx = step_q;
		case (step_q)
			M_UXDY: begin
				op_a = MUL_W'(ux_q); op_b = MUL_W'(dy_q); op_clr = 1'b1; step_nx = M_UYDX;
			end
			M_UYDX: begin
				op_a = MUL_W'(uy_q); op_b = MUL_W'(dx_q); op_sub = 1'b1; step_nx = M_ABS;
			end
			M_ABS: step_nx = M_CHH;
			M_CHH: begin
				op_a = MUL_W'(cabs_q[CABS_W-1:CLO_W]); op_b = op_a;
				op_sh = 6'd48; op_clr = 1'b1; step_nx = M_CHL;
			end
			M_CHL: begin
				op_a = MUL_W'(cabs_q[CABS_W-1:CLO_W]); op_b = MUL_W'(cabs_q[CLO_W-1:0]);
				op_sh = 6'd25; step_nx = M_CLL;
			end
			M_CLL: begin
				op_a = MUL_W'(cabs_q[CLO_W-1:0]); op_b = op_a; step_nx = M_DXDX;
			end
			M_DXDX: begin
				op_a = MUL_W'(dx_q); op_b = op_a; op_clr = 1'b1; step_nx = M_DYDY;
			end
			M_DYDY: begin
				op_a = MUL_W'(dy_q); op_b = op_a; step_nx = M_LLO;
			end
			M_LLO: begin
				op_a = MUL_W'(acc_q[32:0]); op_b = MUL_W'(tol); op_clr = 1'b1;
				step_nx = M_LHI;
			end
			M_LHI: begin
				op_a = MUL_W'(len_q[LEN_W-1:33]); op_b = MUL_W'(tol); op_sh = 6'd33;
				step_nx = M_DONE;
			end
			M_UXUX: begin
				op_a = MUL_W'(ux_q); op_b = op_a; op_clr = 1'b1; step_nx = M_UYUY;
			end
			M_UYUY: begin
				op_a = MUL_W'(uy_q); op_b = op_a; step_nx = M_DGDONE;
			end
			default: step_nx = step_q;
		endcase
	end

	always_comb begin
		acc_base = clr_q ? '0 : acc_q;
		addend   = ACC_W'(prod_q) <<< sh_q;
		acc_nxt  = sub_q ? acc_base - addend : acc_base + addend;
		mag      = acc_q[ACC_W-1] ? -acc_q : acc_q;
		big      = |mag[ACC_W-1:CABS_W];
		if (step_q == M_DGDONE) begin
			pass = $unsigned(acc_q) <= ACC_W'(tol);
		end else begin
			pass = c2_q <= $unsigned(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		emit_req  = 1'b0;
		emit_pt   = q3_q;
		emit_mv   = 1'b0;
		flush_req = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) state_d = pop_data.path_start ? B_START : B_PREP;
			end
			B_START: begin
				emit_pt = q0_q;
				emit_mv = 1'b1;
				if (can_move) begin
					emit_req = 1'b1;
					state_d  = B_PREP;
				end
			end
			B_PREP: begin
				state_d = (lvl_q >= LVL_W'(MAX_DEPTH)) ? B_ACCEPT : B_MAC;
			end
			B_MAC: begin
				if (step_q == M_ABS && big) begin
					state_d = B_SPLIT;
				end else if (step_q == M_DONE || step_q == M_DGDONE) begin
					if (!pass) state_d = B_SPLIT;
					else state_d = sel_q ? B_ACCEPT : B_PREP;
				end
			end
			B_ACCEPT: begin
				if (q3_q != prev_q) begin
					if (can_move) begin
						emit_req = 1'b1;
						state_d  = (sp_q == '0) ? B_CLOSE : B_POP;
					end
				end else begin
					state_d = (sp_q == '0) ? B_CLOSE : B_POP;
				end
			end
			B_POP: state_d = B_PREP;
			B_SPLIT: state_d = B_SPLIT2;
			B_SPLIT2: state_d = B_PREP;
			B_CLOSE: begin
				emit_pt = first_q;
				if (end_q && (!closed_q || prev_q != first_q)) begin
					if (can_move) begin
						emit_req = 1'b1;
						state_d  = B_FLUSH;
					end
				end else begin
					state_d = B_FLUSH;
				end
			end
			B_FLUSH: begin
				if (!pend_v_q) begin
					state_d = B_IDLE;
				end else if (can_out) begin
					flush_req = 1'b1;
					state_d   = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Control state and the path bookkeeping points.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			lvl_q    <= '0;
			sel_q    <= 1'b0;
			ph_q     <= 1'b0;
			step_q   <= M_UXDY;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			prev_q   <= '0;
			first_q  <= '0;
		end else begin
			// The output register refills only when it is free or drains this cycle.
			out_v_q <= (out_v_q && !point.ready) || (emit_req && pend_v_q) || flush_req;
			if (emit_req) begin
				pend_v_q <= 1'b1;
				prev_q   <= emit_pt;
			end
			if (flush_req) begin
				pend_v_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						sp_q  <= '0;
						lvl_q <= '0;
						sel_q <= 1'b0;
					end
				end
				B_START: begin
					if (emit_req) first_q <= q0_q;
				end
				B_PREP: begin
					ph_q   <= 1'b0;
					step_q <= (q3_q == q0_q) ? M_UXUX : M_UXDY;
				end
				B_MAC: begin
					if (step_q == M_ABS) begin
						step_q <= step_nx;
					end else if (step_q == M_DONE || step_q == M_DGDONE) begin
						if (pass) sel_q <= 1'b1;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) step_q <= step_nx;
					end
				end
				B_POP: begin
					sp_q  <= sp_dec;
					lvl_q <= stk_lvl[sp_dec[IDX_W-1:0]];
					sel_q <= 1'b0;
				end
				B_SPLIT2: begin
					sp_q  <= sp_q + 1'b1;
					lvl_q <= LVL_W'(lvl_q + 1'b1);
					sel_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (emit_req) begin
			pend_q    <= emit_pt;
			pend_mv_q <= emit_mv;
		end
		if ((emit_req && pend_v_q) || flush_req) begin
			out_q.point_x  <= 32'(pend_q.x);
			out_q.point_y  <= 32'(pend_q.y);
			out_q.move_to  <= pend_mv_q;
			out_q.run_last <= flush_req;
		end
		case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					q0_q     <= '{crd_t'(pop_data.start_x[CW-1:0]), crd_t'(pop_data.start_y[CW-1:0])};
					q1_q     <= '{crd_t'(pop_data.ctrl1_x[CW-1:0]), crd_t'(pop_data.ctrl1_y[CW-1:0])};
					q2_q     <= '{crd_t'(pop_data.ctrl2_x[CW-1:0]), crd_t'(pop_data.ctrl2_y[CW-1:0])};
					q3_q     <= '{crd_t'(pop_data.end_x[CW-1:0]), crd_t'(pop_data.end_y[CW-1:0])};
					end_q    <= pop_data.path_end;
					closed_q <= pop_data.path_closed;
				end
			end
			B_PREP: begin
				ux_q <= subc(tp.x, q0_q.x);
				uy_q <= subc(tp.y, q0_q.y);
				dx_q <= subc(q3_q.x, q0_q.x);
				dy_q <= subc(q3_q.y, q0_q.y);
			end
			B_MAC: begin
				if (step_q == M_ABS) begin
					cabs_q <= mag[CABS_W-1:0];
				end else if (step_q != M_DONE && step_q != M_DGDONE) begin
					if (!ph_q) begin
						prod_q <= op_a * op_b;
						sh_q   <= op_sh;
						sub_q  <= op_sub;
						clr_q  <= op_clr;
						if (step_q == M_DXDX) c2_q <= acc_q;
						if (step_q == M_LLO) len_q <= acc_q[LEN_W-1:0];
					end else begin
						acc_q <= acc_nxt;
					end
				end
			end
			B_POP: begin
				q0_q <= stk_p0[sp_dec[IDX_W-1:0]];
				q1_q <= stk_p1[sp_dec[IDX_W-1:0]];
				q2_q <= stk_p2[sp_dec[IDX_W-1:0]];
				q3_q <= stk_p3[sp_dec[IDX_W-1:0]];
			end
			B_SPLIT: begin
				ma_q <= midp(q0_q, q1_q);
				mb_q <= midp(q1_q, q2_q);
				mc_q <= midp(q2_q, q3_q);
			end
			B_SPLIT2: begin
				// The left half is worked on at once; the right half waits.
				q1_q <= ma_q;
				q2_q <= sp_ab;
				q3_q <= sp_m;
			end
			default: ;
		endcase
	end

	// Subdivision stack.
	always_ff @(posedge clk) begin
		if (state_q == B_SPLIT2) begin
			stk_p0[sp_q[IDX_W-1:0]]  <= sp_m;
			stk_p1[sp_q[IDX_W-1:0]]  <= sp_bc;
			stk_p2[sp_q[IDX_W-1:0]]  <= mc_q;
			stk_p3[sp_q[IDX_W-1:0]]  <= q3_q;
			stk_lvl[sp_q[IDX_W-1:0]] <= LVL_W'(lvl_q + 1'b1);
		end
	end

	ap_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(SLOTS))
		else $error("subdivision stack overflow");

	ap_idle_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_IDLE |-> !pend_v_q)
		else $error("pending point left behind at end of request");

	ap_level_cap: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LVL_W'(MAX_DEPTH))
		else $error("subdivision level above cap");

endmodule

// ----- design/cubic_bezier_flattener_unit.sv -----
// Each inner control point test runs on one shared 34x34 multiply-accumulate unit
// (a collapsed chord gets a distance test instead), and a split passes through the
// states B_SPLIT and B_SPLIT2. The engine works on one segment at a time; the queue
// lets the next request wait meanwhile. Reset clears control state, the previous and path
// start points and loads tolerance 42949; the subdivision stack is left uninitialized.
module cubic_bezier_flattener_unit import bzf_pkg::*; #(
	parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bzf_stream_if.sink   segment,
	bzf_stream_if.source point,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);

	// The front stage registers each segment request and narrows its
	// coordinates; the queue decouples it from the subdivision engine, which
	// walks the de Casteljau tree depth first on a small stack.

	logic        push_valid, push_ready;
	seg_t        push_data;
	logic        pop_valid, pop_ready;
	seg_t        pop_data;
	logic [31:0] tol_q;

	// The tolerance is stored already clamped to its floor so the engine
	// sees a registered operand.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= (cfg_wdata < TOL_FLOOR) ? TOL_FLOOR : cfg_wdata;
		end
	end

	bzf_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.segment    (segment),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bzf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The engine holds one point back so it can mark the last point of
	// each request once the request's work is done.
	bzf_back #(.MAX_DEPTH(MAX_DEPTH), .COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tol       (tol_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.point     (point)
	);

endmodule
